/* design/vpsl_pkg.sv */
package vpsl_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned RateW  = 10;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_TARGET_X  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_TARGET_Y  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_TARGET_Z  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SPEED_ON  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MAX_SPEED = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_ENABLED   = 3'd5;

  typedef struct packed {
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
    logic                     arrived;
    logic                     moving;
  } vpsl_out_t;

  typedef struct packed {
    logic [RateW-1:0] frame_rate;
  } vpsl_in_t;

endpackage

/* design/vpsl_if.sv */
interface vpsl_in_if;
  import vpsl_pkg::*;
  logic     valid;
  logic     ready;
  vpsl_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vpsl_out_if;
  import vpsl_pkg::*;
  logic      valid;
  logic      ready;
  vpsl_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/vpsl_divu.sv */
// Restoring divider, one quotient bit per cycle.
module vpsl_divu #(
  parameter int unsigned NumW = 64,
  parameter int unsigned DenW = 34
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  output logic            done,
  output logic [NumW-1:0] quo
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] q_r, q_nxt;
  logic [DenW:0]   rem_r, rem_nxt;
  logic [DenW-1:0] den_r;
  logic [CntW-1:0] cnt_r;
  logic            busy_r;
  logic [DenW:0]   trial;
  logic [DenW+1:0] diff;

  assign trial = {rem_r[DenW-1:0], q_r[NumW-1]};
  assign diff  = {1'b0, trial} - {2'b0, den_r};

  always_comb begin
    if (!diff[DenW+1]) begin
      rem_nxt = diff[DenW:0];
      q_nxt   = {q_r[NumW-2:0], 1'b1};
    end else begin
      rem_nxt = trial;
      q_nxt   = {q_r[NumW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(NumW);
        q_r    <= num;
        rem_r  <= '0;
        den_r  <= den;
      end else if (busy_r) begin
        q_r   <= q_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign quo = q_r;
endmodule

/* design/vpsl_isqrt.sv */
// Bit-serial integer square root, two radicand bits per cycle.
module vpsl_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [67:0] rad,
  output logic        done,
  output logic [33:0] root
);
  logic [67:0] rad_r;
  logic [35:0] rem_r, rem_nxt;
  logic [33:0] root_r, root_nxt;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic [35:0] trial;
  logic [36:0] diff;

  assign trial = {rem_r[33:0], rad_r[67:66]};
  assign diff  = {1'b0, trial} - {1'b0, root_r, 2'b01};

  always_comb begin
    if (!diff[36]) begin
      rem_nxt  = diff[35:0];
      root_nxt = {root_r[32:0], 1'b1};
    end else begin
      rem_nxt  = trial;
      root_nxt = {root_r[32:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd34;
        rad_r  <= rad;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        rad_r  <= {rad_r[65:0], 2'b00};
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign root = root_r;
endmodule

/* design/vector_position_slew_limiter.sv */
// Vector position slew limiter.
// Input channel carries one tick request with the frame rate. The output
// channel returns the new position (Q16.16 per axis) plus arrived/moving flags.
// Config is a plain write port (index 0..5: target x/y/z, speed_limit_on,
// max_speed, enabled). Write it only while no request is in flight.
// Path through the machine, from the accepted request to out valid:
//   disabled or on target: apply and output; snap: three squares, one per cycle;
//   smoothing: three bit-serial divides by ten;
//   speed limit, target nearer than one step: rate divide;
//   speed limit, partial step: rate divide, square root, then
//   per axis a registered multiply and a divide by the distance.
// One request in flight at a time. in ready is high only while idle, so the
// next request is taken in the cycle after the result is loaded, at the earliest.
// The result sits in an output register. A request is accepted while that
// result waits, but a stalled receiver holds the next result in its last
// state until the register is free.
// Reset clears position, target and config registers and handshake state.
module vector_position_slew_limiter #(
  parameter int unsigned SNAP_DISTANCE_LSB = 7
) (
  input  logic                       clk,
  input  logic                       rst_n,
  vpsl_in_if.sink                    in_ch,
  vpsl_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [vpsl_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0]                cfg_data
);
  import vpsl_pkg::*;

  localparam logic [67:0] SnapSq = 68'(SNAP_DISTANCE_LSB) * 68'(SNAP_DISTANCE_LSB);

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_TEST, S_MDIV, S_MSQ, S_MTEST, S_SQRT,
    S_AXMUL, S_AXGO, S_AXDIV, S_TENDIV, S_APPLY, S_OUT
  } state_t;

  state_t state_r;

  logic signed [31:0] tgt_r [3];
  logic signed [31:0] cur_r [3];
  logic        spd_on_r, en_r;
  logic [31:0] max_speed_r;
  logic [9:0]  rate_r;
  logic [32:0] mag_r [3];
  logic        neg_r [3];
  logic [67:0] ssum_r;
  logic [1:0]  ax_r;
  logic [33:0] m_r, d_r;
  logic [32:0] step_r [3];
  logic        arrived_r, moving_r;
  logic        spd_path_r;
  logic        out_valid_r;
  vpsl_out_t   out_r;

  // shared multiplier: 33x34, registered
  logic [32:0] mul_a;
  logic [33:0] mul_b;
  logic [66:0] prod_r;

  // divider
  logic        div_start, div_done;
  logic [63:0] div_num, div_quo;
  logic [33:0] div_den;

  logic        sq_start, sq_done;
  logic [33:0] sq_root;

  logic signed [32:0] dlt [3];

  vpsl_divu #(.NumW(64), .DenW(34)) u_div (
    .clk, .rst_n, .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  vpsl_isqrt u_sqrt (
    .clk, .rst_n, .start(sq_start), .rad(ssum_r), .done(sq_done), .root(sq_root)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dlt[i] = {tgt_r[i][31], tgt_r[i]} - {cur_r[i][31], cur_r[i]};
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  always_comb begin
    mul_a = mag_r[ax_r];
    mul_b = {1'b0, mag_r[ax_r]};
    if (state_r == S_MSQ) begin
      mul_a = m_r[32:0];
      mul_b = m_r;
    end else if (state_r == S_AXMUL) begin
      mul_b = m_r;
    end
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = {32'b0, max_speed_r};
    div_den   = {24'b0, rate_r};
    sq_start  = 1'b0;
    case (state_r)
      S_TEST: begin
        if (ssum_r > SnapSq && spd_path_r) div_start = 1'b1;
        else if (ssum_r > SnapSq) begin
          div_start = 1'b1;
          div_num   = {31'b0, mag_r[0]};
          div_den   = 34'd10;
        end
      end
      S_MTEST: sq_start = (ssum_r > {1'b0, prod_r});
      // product |delta| * m was registered in S_AXMUL
      S_AXGO: begin
        div_start = 1'b1;
        div_num   = prod_r[63:0];
        div_den   = d_r;
      end
      S_TENDIV: begin
        div_start = div_done && (ax_r != 2'd2);
        div_num   = {31'b0, mag_r[ax_r + 2'd1]};
        div_den   = 34'd10;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        tgt_r[i] <= '0;
        cur_r[i] <= '0;
      end
      spd_on_r    <= 1'b0;
      en_r        <= 1'b0;
      max_speed_r <= '0;
    end else begin
      // in S_OUT a taken result is replaced by the new one below
      if (out_ch.valid && out_ch.ready && state_r != S_OUT) out_valid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_TARGET_X:  tgt_r[0]    <= cfg_data;
          REG_TARGET_Y:  tgt_r[1]    <= cfg_data;
          REG_TARGET_Z:  tgt_r[2]    <= cfg_data;
          REG_SPEED_ON:  spd_on_r    <= cfg_data[0];
          REG_MAX_SPEED: max_speed_r <= cfg_data;
          REG_ENABLED:   en_r        <= cfg_data[0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            rate_r     <= in_ch.data.frame_rate;
            spd_path_r <= spd_on_r && (in_ch.data.frame_rate != '0);
            arrived_r  <= 1'b0;
            moving_r   <= 1'b0;
            for (int i = 0; i < 3; i++) begin
              neg_r[i]  <= dlt[i][32];
              mag_r[i]  <= dlt[i][32] ? 33'(-dlt[i]) : 33'(dlt[i]);
              step_r[i] <= '0;
            end
            ssum_r <= '0;
            ax_r   <= '0;
            if (!en_r || (dlt[0] == '0 && dlt[1] == '0 && dlt[2] == '0))
              state_r <= S_APPLY;
            else
              state_r <= S_SQ;
          end
        end
        S_SQ: begin
          // product of axis ax_r-1 lands now
          if (ax_r != 2'd0) ssum_r <= ssum_r + {1'b0, prod_r};
          if (ax_r == 2'd3) begin
            state_r <= S_TEST;
            ax_r    <= '0;
          end else begin
            ax_r <= ax_r + 2'd1;
          end
        end
        S_TEST: begin
          if (ssum_r <= SnapSq) begin
            arrived_r <= 1'b1;
            state_r   <= S_APPLY;
          end else if (spd_path_r) begin
            state_r <= S_MDIV;
          end else begin
            state_r <= S_TENDIV;
          end
        end
        S_MDIV: begin
          if (div_done) begin
            m_r     <= {2'b0, div_quo[31:0]};
            state_r <= S_MSQ;
          end
        end
        S_MSQ: state_r <= S_MTEST;
        S_MTEST: begin
          if (ssum_r <= {1'b0, prod_r}) begin
            arrived_r <= 1'b1;
            state_r   <= S_APPLY;
          end else begin
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            d_r     <= sq_root;
            ax_r    <= '0;
            state_r <= S_AXMUL;
          end
        end
        S_AXMUL: state_r <= S_AXGO;
        S_AXGO:  state_r <= S_AXDIV;
        S_AXDIV: begin
          if (div_done) begin
            step_r[ax_r] <= div_quo[32:0];
            if (ax_r == 2'd2) begin
              moving_r <= 1'b1;
              state_r  <= S_APPLY;
            end else begin
              ax_r    <= ax_r + 2'd1;
              state_r <= S_AXMUL;
            end
          end
        end
        S_TENDIV: begin
          if (div_done) begin
            step_r[ax_r] <= div_quo[32:0];
            if (ax_r == 2'd2) begin
              moving_r <= 1'b1;
              state_r  <= S_APPLY;
            end else begin
              ax_r <= ax_r + 2'd1;
            end
          end
        end
        S_APPLY: begin
          for (int i = 0; i < 3; i++) begin
            if (arrived_r) cur_r[i] <= tgt_r[i];
            else if (neg_r[i]) cur_r[i] <= cur_r[i] - step_r[i][31:0];
            else cur_r[i] <= cur_r[i] + step_r[i][31:0];
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_r.pos_x   <= cur_r[0];
            out_r.pos_y   <= cur_r[1];
            out_r.pos_z   <= cur_r[2];
            out_r.arrived <= arrived_r;
            out_r.moving  <= moving_r;
            out_valid_r   <= 1'b1;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
